[hw/rtl/first_fit_page_run_allocator_macros.svh]
// Assertion macros for the page run allocator.
`ifndef FIRST_FIT_PAGE_RUN_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_RUN_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
`define FFPRA_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FFPRA_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FFPRA_ASSERT_IMP(lbl, clk_i, rst_ni, ante, cons)
`define FFPRA_ASSERT_NXT(lbl, clk_i, rst_ni, ante, cons)
`endif

`endif

[hw/rtl/ffpra_pkg.sv]
package ffpra_pkg;

	localparam int PAGES_DEFAULT = 1024;
	localparam int WORD_BITS     = 16;

	localparam int CMD_W    = 1;
	localparam int COUNT_W  = 11;
	localparam int END_W    = 10;
	localparam int STATUS_W = 2;
	localparam int DEPTH_W  = 11;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_RUN = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD    = 2'd2;

	localparam logic [COUNT_W-1:0] USABLE_RESET = 11'd1024;

endpackage

[hw/rtl/first_fit_page_run_allocator.sv]
// First-fit page run allocator. The free-page bitmap lives in one memory of 16-page words
// with a registered read; each request yields one result. After reset a clearing pass over
// all ceil(PAGES/16) words (64 at 1024 pages) sets every page free, and no request is taken
// until it ends; usable_pages writes are taken throughout. An allocate scans one word per
// cycle from page 0 up to the run's end or the limit, then a mark pass covers the words the
// run spans before the result is posted. A free runs only the mark pass; a bad request skips
// both scan and mark. The memory read port is shared by scan and mark. The next request is
// taken while a finished result still waits on the output.
`include "first_fit_page_run_allocator_macros.svh"
module first_fit_page_run_allocator #(
	parameter int PAGES = ffpra_pkg::PAGES_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [ffpra_pkg::COUNT_W-1:0]     cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ffpra_pkg::CMD_W-1:0]       command,
	input  logic [ffpra_pkg::COUNT_W-1:0]     page_count,
	input  logic [ffpra_pkg::END_W-1:0]       run_end_page,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ffpra_pkg::STATUS_W-1:0]    status,
	output logic [ffpra_pkg::END_W-1:0]       found_end_page,
	output logic [ffpra_pkg::DEPTH_W-1:0]     depth_in_use
);

	localparam int WB  = ffpra_pkg::WORD_BITS;
	localparam int OW  = $clog2(WB);
	localparam int NW  = (PAGES + WB - 1) / WB;
	localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
	localparam int XW  = AW + OW;
	localparam int DW  = $clog2(PAGES + 1);
	localparam int MW  = (XW > DW) ? XW : DW;
	localparam int CW  = ((MW > 12) ? MW : 12) + 1;
	localparam int RW  = ffpra_pkg::COUNT_W + 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);
	localparam logic [CW-1:0] PAGES_C   = CW'(PAGES);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_MARK  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]                      state_q;
	logic [ffpra_pkg::COUNT_W-1:0]   usable_q;
	logic [DW-1:0]                   depth_q;
	logic [AW-1:0]                   clr_q;
	logic [AW-1:0]                   scan_rd_q;
	logic [RW-1:0]                   run_q;
	logic [ffpra_pkg::COUNT_W-1:0]   count_q;
	logic [XW-1:0]                   mark_lo_q;
	logic [XW-1:0]                   mark_hi_q;
	logic                            mark_val_q;
	logic [AW-1:0]                   mark_rd_q;
	logic                            mark_issue_q;
	logic [ffpra_pkg::STATUS_W-1:0]  res_status_q;
	logic [XW-1:0]                   res_found_q;

	logic                            scan_vld_s1;
	logic                            mark_vld_s1;
	logic [AW-1:0]                   raddr_s1;
	logic [WB-1:0]                   rdata_s1;

	logic                            out_valid_q;
	logic [ffpra_pkg::STATUS_W-1:0]  status_q;
	logic [ffpra_pkg::END_W-1:0]     found_q;
	logic [ffpra_pkg::DEPTH_W-1:0]   depth_out_q;

	logic [WB-1:0]                   mem [NW];

	logic                            rd_en;
	logic [AW-1:0]                   rd_addr;
	logic                            wr_en;
	logic [AW-1:0]                   wr_addr;
	logic [WB-1:0]                   wr_data;

	logic                            in_fire;
	logic                            out_load;
	logic [CW-1:0]                   limit_c;
	logic [CW-1:0]                   end_c;
	logic [CW-1:0]                   endp1_c;
	logic [CW-1:0]                   cnt_c;
	logic [CW-1:0]                   depth_c;
	logic                            free_bad;

	logic [CW-1:0]                   base_c;
	logic                            free_b;
	logic                            sz;
	logic [OW-1:0]                   lz;
	logic [RW-1:0]                   run_j;
	logic                            hit_c;
	logic [OW-1:0]                   hit_j;
	logic [RW-1:0]                   carry_c;
	logic                            scan_last_c;
	logic [XW-1:0]                   hit_idx_c;
	logic [XW-1:0]                   alloc_lo_c;
	logic [WB-1:0]                   mark_mask_c;
	logic [XW-1:0]                   bit_idx;
	logic [AW-1:0]                   hi_word_c;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign hi_word_c = mark_hi_q[XW-1:OW];

	assign limit_c  = (CW'(usable_q) < PAGES_C) ? CW'(usable_q) : PAGES_C;
	assign end_c    = CW'(run_end_page);
	assign endp1_c  = end_c + CW'(1);
	assign cnt_c    = CW'(page_count);
	assign depth_c  = CW'(depth_q);
	assign free_bad = (end_c >= PAGES_C) || (cnt_c > endp1_c);

	always_comb begin
		base_c  = CW'({raddr_s1, OW'(0)});
		free_b  = 1'b0;
		sz      = 1'b0;
		lz      = '0;
		run_j   = '0;
		hit_c   = 1'b0;
		hit_j   = '0;
		for (int j = 0; j < WB; j++) begin
			free_b = rdata_s1[j] && ((base_c + CW'(j)) < limit_c);
			if (!free_b) begin
				sz = 1'b1;
				lz = OW'(j);
			end
			if (sz) begin
				run_j = RW'(j) - RW'(lz);
			end else begin
				run_j = run_q + RW'(j) + RW'(1);
			end
			if (!hit_c && free_b && (run_j >= RW'(count_q))) begin
				hit_c = 1'b1;
				hit_j = OW'(j);
			end
		end
		carry_c     = sz ? (RW'(WB - 1) - RW'(lz)) : (run_q + RW'(WB));
		scan_last_c = (base_c + CW'(WB)) >= limit_c;
		hit_idx_c   = {raddr_s1, hit_j};
		alloc_lo_c  = hit_idx_c - XW'(count_q) + XW'(1);
	end

	always_comb begin
		bit_idx     = '0;
		mark_mask_c = '0;
		for (int j = 0; j < WB; j++) begin
			bit_idx        = {raddr_s1, OW'(j)};
			mark_mask_c[j] = (bit_idx >= mark_lo_q) && (bit_idx <= mark_hi_q);
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = scan_rd_q;
		wr_en   = 1'b0;
		wr_addr = raddr_s1;
		wr_data = mark_val_q ? (rdata_s1 | mark_mask_c) : (rdata_s1 & ~mark_mask_c);
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '1;
			end
			S_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = scan_rd_q;
			end
			S_MARK: begin
				rd_en   = mark_issue_q;
				rd_addr = mark_rd_q;
				wr_en   = mark_vld_s1;
			end
			default: begin
				rd_en = 1'b0;
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
			raddr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
			mark_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= (state_q == S_SCAN);
			mark_vld_s1 <= (state_q == S_MARK) && mark_issue_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			usable_q <= ffpra_pkg::USABLE_RESET;
		end else if (cfg_wr_en) begin
			usable_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			depth_q      <= '0;
			clr_q        <= '0;
			mark_issue_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_WORD) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						if (page_count == '0) begin
							state_q <= S_DONE;
						end else if (command == ffpra_pkg::CMD_ALLOC) begin
							state_q <= S_SCAN;
						end else if (free_bad) begin
							state_q <= S_DONE;
						end else begin
							state_q      <= S_MARK;
							mark_issue_q <= 1'b1;
							if (depth_c == endp1_c) begin
								depth_q <= DW'(endp1_c - cnt_c);
							end
						end
					end
				end
				S_SCAN: begin
					if (scan_vld_s1) begin
						if (hit_c) begin
							state_q      <= S_MARK;
							mark_issue_q <= 1'b1;
							if (depth_c < (CW'(hit_idx_c) + CW'(1))) begin
								depth_q <= DW'(CW'(hit_idx_c) + CW'(1));
							end
						end else if (scan_last_c) begin
							state_q <= S_DONE;
						end
					end
				end
				S_MARK: begin
					if (mark_issue_q && (mark_rd_q == hi_word_c)) begin
						mark_issue_q <= 1'b0;
					end
					if (mark_vld_s1 && (raddr_s1 == hi_word_c)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request context and mark bounds
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				count_q     <= page_count;
				run_q       <= '0;
				scan_rd_q   <= '0;
				res_found_q <= '0;
				mark_val_q  <= 1'b1;
				mark_lo_q   <= XW'(endp1_c - cnt_c);
				mark_hi_q   <= XW'(end_c);
				mark_rd_q   <= AW'(XW'(endp1_c - cnt_c) >> OW);
				if (page_count == '0) begin
					res_status_q <= ffpra_pkg::STATUS_BAD;
				end else if (command == ffpra_pkg::CMD_FREE && free_bad) begin
					res_status_q <= ffpra_pkg::STATUS_BAD;
				end else begin
					res_status_q <= ffpra_pkg::STATUS_OK;
				end
			end
			S_SCAN: begin
				scan_rd_q <= scan_rd_q + AW'(1);
				if (scan_vld_s1) begin
					run_q <= carry_c;
					if (hit_c) begin
						res_status_q <= ffpra_pkg::STATUS_OK;
						res_found_q  <= hit_idx_c;
						mark_val_q   <= 1'b0;
						mark_lo_q    <= alloc_lo_c;
						mark_hi_q    <= hit_idx_c;
						mark_rd_q    <= alloc_lo_c[XW-1:OW];
					end else if (scan_last_c) begin
						res_status_q <= ffpra_pkg::STATUS_NO_RUN;
						res_found_q  <= '0;
					end
				end
			end
			S_MARK: begin
				if (mark_issue_q && (mark_rd_q != hi_word_c)) begin
					mark_rd_q <= mark_rd_q + AW'(1);
				end
			end
			default: begin
				run_q <= run_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q    <= res_status_q;
			found_q     <= ffpra_pkg::END_W'(res_found_q);
			depth_out_q <= ffpra_pkg::DEPTH_W'(depth_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found_end_page = found_q;
	assign depth_in_use   = depth_out_q;

	`FFPRA_ASSERT_IMP(a_no_write_in_scan, clk, arst_n, state_q == S_SCAN, !wr_en)
	`FFPRA_ASSERT_IMP(a_rmw_no_overlap, clk, arst_n, rd_en && wr_en, rd_addr != wr_addr)
	`FFPRA_ASSERT_IMP(a_depth_bound, clk, arst_n, 1'b1, CW'(depth_q) <= PAGES_C)
	`FFPRA_ASSERT_NXT(a_result_posted, clk, arst_n, out_load, out_valid_q && state_q == S_IDLE)
	`FFPRA_ASSERT_IMP(a_mark_in_run, clk, arst_n, state_q == S_MARK && wr_en, wr_addr <= hi_word_c)

endmodule

[tb/sv/tb_first_fit_page_run_allocator.sv]
module tb_first_fit_page_run_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import ffpra_pkg::*;

	localparam int PAGES        = PAGES_DEFAULT;
	localparam int QUIET_LIMIT  = 4000;
	localparam int LONG_HOLD    = 600;
	localparam int TAIL_CYCLES  = 2 * ((PAGES + WORD_BITS - 1) / WORD_BITS) + 16;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [COUNT_W-1:0] count;
		logic [END_W-1:0]   end_page;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [END_W-1:0]    found;
		logic [DEPTH_W-1:0]  depth;
	} outcome_t;

	typedef struct packed {
		logic [END_W-1:0]   end_page;
		logic [COUNT_W-1:0] count;
	} run_t;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	class page_map_tracker;
		bit          page_free [PAGES];
		int unsigned used_depth;
		int unsigned usable;
		outcome_t    awaiting [$];
		int          errors;

		function new();
			foreach (page_free[i])
				page_free[i] = 1'b1;
			used_depth = 0;
			usable = 32'(USABLE_RESET);
			errors = 0;
		endfunction

		function void set_usable(logic [COUNT_W-1:0] value);
			usable = 32'(value);
		endfunction

		function int pending();
			return awaiting.size();
		endfunction

		function outcome_t note_request(request_t r);
			outcome_t    o;
			int unsigned limit;
			int unsigned streak;
			int unsigned i;
			int unsigned last;
			int unsigned count;
			int unsigned end_page;
			bit          hit;
			o.status = STATUS_OK;
			o.found = '0;
			count = 32'(r.count);
			end_page = 32'(r.end_page);
			if (count == 0) begin
				o.status = STATUS_BAD;
			end else if (r.cmd == CMD_ALLOC) begin
				limit = usable < PAGES ? usable : PAGES;
				streak = 0;
				hit = 1'b0;
				last = 0;
				for (i = 0; i < limit && !hit; i++) begin
					if (page_free[i]) begin
						streak++;
						if (streak == count) begin
							hit = 1'b1;
							last = i;
						end
					end else begin
						streak = 0;
					end
				end
				if (hit) begin
					for (i = last + 1 - count; i <= last; i++)
						page_free[i] = 1'b0;
					o.found = last[END_W-1:0];
					if (used_depth < last + 1)
						used_depth = last + 1;
				end else begin
					o.status = STATUS_NO_RUN;
				end
			end else if (end_page >= PAGES || count > end_page + 1) begin
				o.status = STATUS_BAD;
			end else begin
				for (i = end_page + 1 - count; i <= end_page; i++)
					page_free[i] = 1'b1;
				if (used_depth == end_page + 1)
					used_depth = used_depth - count;
			end
			o.depth = used_depth[DEPTH_W-1:0];
			awaiting.push_back(o);
			return o;
		endfunction

		function void check_result(outcome_t got);
			outcome_t want;
			if (awaiting.size() == 0) begin
				$error("unexpected result: status %0d found_end_page %0d depth_in_use %0d",
					got.status, got.found, got.depth);
				errors++;
				return;
			end
			want = awaiting.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, got.status);
				errors++;
			end
			if (got.found !== want.found) begin
				$error("found_end_page: expected %0d, actual %0d", want.found, got.found);
				errors++;
			end
			if (got.depth !== want.depth) begin
				$error("depth_in_use: expected %0d, actual %0d", want.depth, got.depth);
				errors++;
			end
		endfunction
	endclass

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_wr_en    = 1'b0;
	logic [COUNT_W-1:0]  cfg_wr_data  = USABLE_RESET;
	logic                in_valid     = 1'b0;
	logic                in_ready;
	logic [CMD_W-1:0]    command      = CMD_ALLOC;
	logic [COUNT_W-1:0]  page_count   = '0;
	logic [END_W-1:0]    run_end_page = '0;
	logic                out_valid;
	logic                out_ready    = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [END_W-1:0]    found_end_page;
	logic [DEPTH_W-1:0]  depth_in_use;

	page_map_tracker tracker;
	run_t            runs [$];
	int unsigned     sender_idle_pct = 0;
	int unsigned     stall_pct       = 0;
	bit              long_hold_req   = 1'b0;
	int              hold_left       = 0;
	int              quiet_cycles    = 0;

	first_fit_page_run_allocator #(
		.PAGES(PAGES)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.page_count    (page_count),
		.run_end_page  (run_end_page),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.found_end_page(found_end_page),
		.depth_in_use  (depth_in_use)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin : receive
		outcome_t seen;
		if (out_valid && out_ready) begin
			seen.status = status;
			seen.found = found_end_page;
			seen.depth = depth_in_use;
			tracker.check_result(seen);
		end
		if (long_hold_req) begin
			hold_left = LONG_HOLD;
			long_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic request_t make_request(logic [CMD_W-1:0] cmd, int count, int end_page);
		request_t r;
		r.cmd = cmd;
		r.count = count[COUNT_W-1:0];
		r.end_page = end_page[END_W-1:0];
		return r;
	endfunction

	function automatic request_t pick_request();
		request_t r;
		run_t     run;
		run_t     rest;
		int       idx;
		int       roll;
		int       span;
		roll = $urandom_range(99, 0);
		r.cmd = CMD_ALLOC;
		r.end_page = END_W'($urandom);
		r.count = '0;
		if (roll < 8) begin
			r.cmd = $urandom_range(1, 0) ? CMD_FREE : CMD_ALLOC;
			r.count = COUNT_W'($urandom_range(2047, 0));
			if ($urandom_range(3, 0) == 0)
				r.count = '0;
			if ($urandom_range(4, 0) == 0) begin
				r = make_request(CMD_FREE, PAGES, PAGES - 1);
				runs.delete();
			end
		end else if (runs.size() != 0 && (roll >= 55 || runs.size() > 40)) begin
			idx = $urandom_range(runs.size() - 1, 0);
			run = runs[idx];
			runs.delete(idx);
			r.cmd = CMD_FREE;
			r.end_page = run.end_page;
			r.count = run.count;
			if ($urandom_range(9, 0) == 0) begin
				r.count = COUNT_W'($urandom_range(run.count, 1));
				if (r.count < run.count) begin
					rest.end_page = END_W'(run.end_page - r.count);
					rest.count = run.count - r.count;
					runs.push_back(rest);
				end
			end
		end else begin
			span = $urandom_range(99, 0);
			if (span < 70)
				r.count = COUNT_W'($urandom_range(16, 1));
			else if (span < 95)
				r.count = COUNT_W'($urandom_range(128, 1));
			else
				r.count = COUNT_W'($urandom_range(2047, 1));
		end
		return r;
	endfunction

	task automatic send_request(input request_t r);
		outcome_t o;
		run_t     run;
		while ($urandom_range(99, 0) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= r.cmd;
		page_count <= r.count;
		run_end_page <= r.end_page;
		do @(posedge clk); while (!in_ready);
		o = tracker.note_request(r);
		if (r.cmd == CMD_ALLOC && o.status == STATUS_OK) begin
			run.end_page = o.found;
			run.count = r.count;
			runs.push_back(run);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	task automatic set_usable(input logic [COUNT_W-1:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		tracker.set_usable(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(input logic [COUNT_W-1:0] limit, input idle_mode_t mode,
		input int items, input bit hold_receiver, input bit pause_midway);
		set_usable(limit);
		case (mode)
			IDLE_NONE: begin
				sender_idle_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				sender_idle_pct = 78;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_idle_pct = 0;
				stall_pct = 78;
			end
			default: begin
				sender_idle_pct = 6;
				stall_pct = 6;
			end
		endcase
		if (hold_receiver)
			long_hold_req = 1'b1;
		for (int n = 0; n < items; n++) begin
			if (pause_midway && n == items / 2)
				drain();
			send_request(pick_request());
		end
	endtask

	initial begin
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		set_usable(USABLE_RESET);
		send_request(make_request(CMD_ALLOC, 0, 0));
		send_request(make_request(CMD_FREE, 0, 9));
		send_request(make_request(CMD_ALLOC, 1, 0));
		send_request(make_request(CMD_ALLOC, 16, 1023));
		send_request(make_request(CMD_ALLOC, 1024, 0));
		send_request(make_request(CMD_ALLOC, 2047, 0));
		send_request(make_request(CMD_FREE, 1024, 1023));
		send_request(make_request(CMD_ALLOC, 1024, 0));
		send_request(make_request(CMD_FREE, 1024, 1023));
		send_request(make_request(CMD_FREE, 7, 5));
		send_request(make_request(CMD_FREE, 1, 0));
		send_request(make_request(CMD_ALLOC, 3, 0));
		send_request(make_request(CMD_ALLOC, 5, 0));
		send_request(make_request(CMD_FREE, 3, 2));
		send_request(make_request(CMD_FREE, 5, 7));
		send_request(make_request(CMD_FREE, 2047, 1023));
		send_request(make_request(CMD_ALLOC, 1, 0));
		set_usable(COUNT_W'(0));
		send_request(make_request(CMD_ALLOC, 1, 0));
		set_usable(COUNT_W'(2047));
		send_request(make_request(CMD_ALLOC, 1023, 0));
		send_request(make_request(CMD_FREE, 1024, 1023));
		set_usable(COUNT_W'(1));
		send_request(make_request(CMD_ALLOC, 1, 0));
		send_request(make_request(CMD_ALLOC, 1, 0));
		send_request(make_request(CMD_FREE, 1, 0));
		runs.delete();

		run_phase(COUNT_W'(1024), IDLE_NONE, 50, 1'b1, 1'b0);
		run_phase(COUNT_W'(2047), IDLE_SENDER, 50, 1'b0, 1'b0);
		run_phase(COUNT_W'(0), IDLE_RECEIVER, 30, 1'b0, 1'b0);
		run_phase(COUNT_W'(1), IDLE_BOTH, 40, 1'b0, 1'b0);
		run_phase(COUNT_W'(40), IDLE_NONE, 50, 1'b0, 1'b1);
		run_phase(COUNT_W'(1025), IDLE_RECEIVER, 50, 1'b0, 1'b0);
		run_phase(COUNT_W'(300), IDLE_SENDER, 50, 1'b0, 1'b0);
		run_phase(COUNT_W'(1023), IDLE_BOTH, 60, 1'b0, 1'b0);
		run_phase(COUNT_W'($urandom_range(2047, 0)), IDLE_NONE, 70, 1'b0, 1'b0);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
